@@ rtl/svvl_pkg.sv @@
// shared constants, types and helpers of the six-phase voltage vector limiter
package svvl_pkg;

    localparam int VOLT_W      = 32;
    localparam int DC_W        = VOLT_W - 1;
    localparam int MOD_W       = 17;
    localparam int Q_BITS      = 16;
    localparam int SQ_W        = 2 * VOLT_W;
    localparam int SCALE_W     = VOLT_W + Q_BITS;
    localparam int DCPROD_W    = DC_W + MOD_W;
    localparam int ROOT_STAGES = VOLT_W;
    localparam int REM_W       = VOLT_W + 2;

    localparam logic [MOD_W-1:0]  MOD_RESET     = MOD_W'(37837);
    localparam logic [Q_BITS-1:0] CAP_Q16       = Q_BITS'(62259);
    localparam logic [Q_BITS-1:0] INV_SQRT2_Q16 = Q_BITS'(46341);

    typedef logic [VOLT_W-1:0] mag_t;
    typedef logic [SQ_W-1:0]   sq_t;

    typedef struct packed {
        mag_t d_mag;
        mag_t q_mag;
        mag_t x_mag;
        mag_t y_mag;
        logic d_neg;
        logic q_neg;
        logic x_neg;
        logic y_neg;
        logic d_prio;
        mag_t vmax;
        logic clamp_xy;
    } item_t;

    typedef struct packed {
        item_t item;
        mag_t  pm;
        mag_t  o_mag;
        logic  clamp;
    } side_t;

    function automatic sq_t square(mag_t a);
        return sq_t'(a) * sq_t'(a);
    endfunction

endpackage

@@ rtl/six_phase_voltage_vector_limiter_top.sv @@
// top level of the six-phase voltage vector limiter
// Limits a d/q/x/y voltage reference to Vmax = dc_link_volt * modulation_limit. The xy pair
// is cut first to Vmax/sqrt2 with y as priority axis, then dq to the remaining magnitude with
// d or q as priority axis depending on the signs of elec_speed and current_ref_q. The block is
// a pipeline that takes one transaction per cycle while the output is not stalled; the three
// 32-stage square root units make up most of its depth. When a result is stalled
// at the output the whole pipeline holds and in_stall rises.
module six_phase_voltage_vector_limiter_top
    import svvl_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [2:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic signed [VOLT_W-1:0] volt_d_in,
    input  logic signed [VOLT_W-1:0] volt_q_in,
    input  logic signed [VOLT_W-1:0] volt_x_in,
    input  logic signed [VOLT_W-1:0] volt_y_in,
    input  logic [DC_W-1:0]          dc_link_volt,
    input  logic signed [VOLT_W-1:0] elec_speed,
    input  logic signed [VOLT_W-1:0] current_ref_q,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [VOLT_W-1:0] volt_d_out,
    output logic signed [VOLT_W-1:0] volt_q_out,
    output logic signed [VOLT_W-1:0] volt_x_out,
    output logic signed [VOLT_W-1:0] volt_y_out,
    output logic                     clamped
);

    localparam logic REG_MOD_LIMIT = 1'b0;

    logic [MOD_W-1:0]    mod_reg;
    logic                en;

    logic                v_f1_reg, v_f2_reg, v_m1_reg, v_m2_reg;
    item_t               item_f1_reg, item_f2_reg, item_m1_reg;
    logic [DCPROD_W-1:0] dcprod_reg;
    logic [SCALE_W-1:0]  lprod_reg;
    sq_t                 xsq_reg, ysq_reg, vsq_reg, rad_m2_reg;
    side_t               side_m2_reg;

    item_t               item_f1_next, item_f2_next, item_m1_next;
    mag_t                vmax;
    logic                w_neg, w_zero, iq_neg, iq_zero;
    logic [SQ_W:0]       xy_sum;

    logic                v_xy, v_ldq, v_dq;
    item_t               item_xy, item_dq;
    mag_t                po_xy, oo_xy, po_dq, oo_dq;
    logic                clamp_xy, clamp_dq;
    mag_t                ldq;
    side_t               side_ldq;
    mag_t                dq_p, dq_o, d_new, q_new;

    function automatic mag_t abs_mag(mag_t v);
        return v[VOLT_W-1] ? mag_t'(-v) : v;
    endfunction

    function automatic mag_t apply_sign(mag_t m, logic neg);
        return neg ? mag_t'(-m) : m;
    endfunction

    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;
    assign pready   = 1'b1;

    // configuration port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mod_reg <= MOD_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_MOD_LIMIT))
        begin
            mod_reg <= pwdata[MOD_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_MOD_LIMIT) ? 32'(mod_reg) : '0;

    // decode and limit scaling
    assign w_neg   = elec_speed[VOLT_W-1];
    assign w_zero  = (elec_speed == '0);
    assign iq_neg  = current_ref_q[VOLT_W-1];
    assign iq_zero = (current_ref_q == '0);

    always_comb
    begin
        item_f1_next          = '0;
        item_f1_next.d_mag    = abs_mag(volt_d_in);
        item_f1_next.q_mag    = abs_mag(volt_q_in);
        item_f1_next.x_mag    = abs_mag(volt_x_in);
        item_f1_next.y_mag    = abs_mag(volt_y_in);
        item_f1_next.d_neg    = volt_d_in[VOLT_W-1];
        item_f1_next.q_neg    = volt_q_in[VOLT_W-1];
        item_f1_next.x_neg    = volt_x_in[VOLT_W-1];
        item_f1_next.y_neg    = volt_y_in[VOLT_W-1];
        item_f1_next.d_prio   = (w_zero == iq_zero) && (w_zero || (w_neg == iq_neg));
    end

    assign vmax = dcprod_reg[Q_BITS +: VOLT_W];

    always_comb
    begin
        item_f2_next      = item_f1_reg;
        item_f2_next.vmax = vmax;
    end

    // write back of the limited xy pair
    always_comb
    begin
        item_m1_next          = item_xy;
        item_m1_next.y_mag    = po_xy;
        item_m1_next.x_mag    = oo_xy;
        item_m1_next.clamp_xy = clamp_xy;
    end

    assign xy_sum = {1'b0, xsq_reg} + {1'b0, ysq_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_f1_reg  <= 1'b0;
            v_f2_reg  <= 1'b0;
            v_m1_reg  <= 1'b0;
            v_m2_reg  <= 1'b0;
            out_valid <= 1'b0;
        end
        else if (en)
        begin
            v_f1_reg  <= in_valid;
            v_f2_reg  <= v_f1_reg;
            v_m1_reg  <= v_xy;
            v_m2_reg  <= v_m1_reg;
            out_valid <= v_dq;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_f1_reg <= item_f1_next;
            dcprod_reg  <= DCPROD_W'(dc_link_volt) * DCPROD_W'(mod_reg);

            item_f2_reg <= item_f2_next;
            lprod_reg   <= SCALE_W'(vmax) * SCALE_W'(INV_SQRT2_Q16);

            item_m1_reg <= item_m1_next;
            xsq_reg     <= square(oo_xy);
            ysq_reg     <= square(po_xy);
            vsq_reg     <= square(item_xy.vmax);

            side_m2_reg.item  <= item_m1_reg;
            side_m2_reg.pm    <= '0;
            side_m2_reg.o_mag <= '0;
            side_m2_reg.clamp <= 1'b0;
            rad_m2_reg        <= (xy_sum > {1'b0, vsq_reg}) ? '0 : SQ_W'({1'b0, vsq_reg} - xy_sum);

            volt_d_out <= apply_sign(d_new, item_dq.d_neg);
            volt_q_out <= apply_sign(q_new, item_dq.q_neg);
            volt_x_out <= apply_sign(item_dq.x_mag, item_dq.x_neg);
            volt_y_out <= apply_sign(item_dq.y_mag, item_dq.y_neg);
            clamped    <= item_dq.clamp_xy || clamp_dq;
        end
    end

    svvl_pair u_pair_xy (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (v_f2_reg),
        .item_in  (item_f2_reg),
        .lim      (lprod_reg[Q_BITS +: VOLT_W]),
        .p_mag    (item_f2_reg.y_mag),
        .o_mag    (item_f2_reg.x_mag),
        .out_valid(v_xy),
        .item_out (item_xy),
        .po_mag   (po_xy),
        .oo_mag   (oo_xy),
        .clamp    (clamp_xy)
    );

    svvl_isqrt u_isqrt_ldq (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (v_m2_reg),
        .rad      (rad_m2_reg),
        .side_in  (side_m2_reg),
        .out_valid(v_ldq),
        .root     (ldq),
        .side_out (side_ldq)
    );

    assign dq_p = side_ldq.item.d_prio ? side_ldq.item.d_mag : side_ldq.item.q_mag;
    assign dq_o = side_ldq.item.d_prio ? side_ldq.item.q_mag : side_ldq.item.d_mag;

    svvl_pair u_pair_dq (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (v_ldq),
        .item_in  (side_ldq.item),
        .lim      (ldq),
        .p_mag    (dq_p),
        .o_mag    (dq_o),
        .out_valid(v_dq),
        .item_out (item_dq),
        .po_mag   (po_dq),
        .oo_mag   (oo_dq),
        .clamp    (clamp_dq)
    );

    assign d_new = item_dq.d_prio ? po_dq : oo_dq;
    assign q_new = item_dq.d_prio ? oo_dq : po_dq;

endmodule

@@ rtl/svvl_isqrt.sv @@
// pipelined integer square root, one result bit per stage, with sideband
module svvl_isqrt
    import svvl_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  logic  in_valid,
    input  sq_t   rad,
    input  side_t side_in,
    output logic  out_valid,
    output mag_t  root,
    output side_t side_out
);

    logic [ROOT_STAGES-1:0] v_reg;
    sq_t                    n_reg    [ROOT_STAGES];
    logic [REM_W-1:0]       rem_reg  [ROOT_STAGES];
    mag_t                   root_reg [ROOT_STAGES];
    side_t                  side_reg [ROOT_STAGES];

    for (genvar k = 0; k < ROOT_STAGES; k++) begin : g_stage
        logic             v_prev;
        sq_t              n_prev;
        logic [REM_W-1:0] rem_prev;
        mag_t             root_prev;
        side_t            side_prev;
        logic [REM_W+1:0] cur;
        logic [REM_W+1:0] trial;
        logic             ge;

        if (k == 0) begin : g_first
            assign v_prev    = in_valid;
            assign n_prev    = rad;
            assign rem_prev  = '0;
            assign root_prev = '0;
            assign side_prev = side_in;
        end
        else begin : g_next
            assign v_prev    = v_reg[k-1];
            assign n_prev    = n_reg[k-1];
            assign rem_prev  = rem_reg[k-1];
            assign root_prev = root_reg[k-1];
            assign side_prev = side_reg[k-1];
        end

        assign cur   = {rem_prev, n_prev[SQ_W-1 -: 2]};
        assign trial = {2'b00, root_prev, 2'b01};
        assign ge    = (cur >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k] <= v_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                n_reg[k]    <= {n_prev[SQ_W-3:0], 2'b00};
                rem_reg[k]  <= ge ? REM_W'(cur - trial) : REM_W'(cur);
                root_reg[k] <= {root_prev[VOLT_W-2:0], ge};
                side_reg[k] <= side_prev;
            end
        end
    end

    assign out_valid = v_reg[ROOT_STAGES-1];
    assign root      = root_reg[ROOT_STAGES-1];
    assign side_out  = side_reg[ROOT_STAGES-1];

endmodule

@@ rtl/svvl_pair.sv @@
// pair limiter with priority axis: overflow test, 0.95 cap, remaining magnitude
module svvl_pair
    import svvl_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  logic  in_valid,
    input  item_t item_in,
    input  mag_t  lim,
    input  mag_t  p_mag,
    input  mag_t  o_mag,
    output logic  out_valid,
    output item_t item_out,
    output mag_t  po_mag,
    output mag_t  oo_mag,
    output logic  clamp
);

    logic                 v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    item_t                item1_reg, item2_reg, item3_reg;
    mag_t                 p1_reg, o1_reg, o2_reg, o3_reg, pm2_reg, pm3_reg;
    sq_t                  psq1_reg, osq1_reg, lsq1_reg, lsq2_reg, lsq3_reg, pmsq3_reg;
    logic [SCALE_W-1:0]   capp1_reg;
    logic                 clamp2_reg, clamp3_reg;
    side_t                side4_reg;
    sq_t                  rad4_reg;

    logic                 clamp2_next;
    mag_t                 cap;
    mag_t                 pm2_next;

    logic                 vr;
    mag_t                 root;
    side_t                sider;

    assign clamp2_next = ({1'b0, psq1_reg} + {1'b0, osq1_reg}) > {1'b0, lsq1_reg};
    assign cap         = capp1_reg[Q_BITS +: VOLT_W];
    assign pm2_next    = (clamp2_next && (p1_reg > cap)) ? cap : p1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= vr;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item1_reg  <= item_in;
            p1_reg     <= p_mag;
            o1_reg     <= o_mag;
            psq1_reg   <= square(p_mag);
            osq1_reg   <= square(o_mag);
            lsq1_reg   <= square(lim);
            capp1_reg  <= SCALE_W'(lim) * SCALE_W'(CAP_Q16);

            item2_reg  <= item1_reg;
            pm2_reg    <= pm2_next;
            o2_reg     <= o1_reg;
            lsq2_reg   <= lsq1_reg;
            clamp2_reg <= clamp2_next;

            item3_reg  <= item2_reg;
            pm3_reg    <= pm2_reg;
            o3_reg     <= o2_reg;
            lsq3_reg   <= lsq2_reg;
            clamp3_reg <= clamp2_reg;
            pmsq3_reg  <= square(pm2_reg);

            side4_reg.item  <= item3_reg;
            side4_reg.pm    <= pm3_reg;
            side4_reg.o_mag <= o3_reg;
            side4_reg.clamp <= clamp3_reg;
            rad4_reg        <= lsq3_reg - pmsq3_reg;

            item_out <= sider.item;
            po_mag   <= sider.pm;
            oo_mag   <= (sider.clamp && (sider.o_mag != '0)) ? root : sider.o_mag;
            clamp    <= sider.clamp;
        end
    end

    svvl_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (v4_reg),
        .rad      (rad4_reg),
        .side_in  (side4_reg),
        .out_valid(vr),
        .root     (root),
        .side_out (sider)
    );

    assign out_valid = v5_reg;

endmodule

@@ rtl/svvl_checker.sv @@
// port level checks of the six-phase voltage vector limiter
module svvl_props
    import svvl_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_stall,
    input logic                     out_valid,
    input logic                     out_stall,
    input logic signed [VOLT_W-1:0] volt_d_out,
    input logic                     clamped
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(volt_d_out) && $stable(clamped))
        else $error("stalled result changed");

    a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with empty output");

    a_stall_follows_output: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall |-> !in_stall)
        else $error("input stalled while result drains");

    a_reset_empty: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result valid during reset");

endmodule

bind six_phase_voltage_vector_limiter_top svvl_props u_svvl_props (.*);

@@ verif/svvl_checker.sv @@
// checker of the six-phase voltage vector limiter: watches both channels, predicts and compares
module svvl_checker
    import svvl_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic                     in_stall,
    input  logic signed [VOLT_W-1:0] volt_d_in,
    input  logic signed [VOLT_W-1:0] volt_q_in,
    input  logic signed [VOLT_W-1:0] volt_x_in,
    input  logic signed [VOLT_W-1:0] volt_y_in,
    input  logic [DC_W-1:0]          dc_link_volt,
    input  logic signed [VOLT_W-1:0] elec_speed,
    input  logic signed [VOLT_W-1:0] current_ref_q,
    input  logic                     out_valid,
    input  logic                     out_stall,
    input  logic signed [VOLT_W-1:0] volt_d_out,
    input  logic signed [VOLT_W-1:0] volt_q_out,
    input  logic signed [VOLT_W-1:0] volt_x_out,
    input  logic signed [VOLT_W-1:0] volt_y_out,
    input  logic                     clamped,
    input  logic [MOD_W-1:0]         mod_index,
    output int                       fail_count,
    output int                       pending,
    output int                       accepted_in,
    output int                       accepted_out,
    output int                       clamp_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [VOLT_W-1:0] d;
        logic [VOLT_W-1:0] q;
        logic [VOLT_W-1:0] x;
        logic [VOLT_W-1:0] y;
        logic              clamp;
    } limited_t;

    typedef struct {
        int          sg;
        logic [63:0] mag;
    } axis_t;

    limited_t limited_q[$];

    function automatic axis_t split(logic [VOLT_W-1:0] v);
        axis_t a;
        a.sg = (v == 0) ? 0 : (v[VOLT_W-1] ? -1 : 1);
        a.mag = v[VOLT_W-1] ? 64'(-v) : 64'(v);
        a.mag = a.mag & ((64'd1 << VOLT_W) - 1);
        return a;
    endfunction

    function automatic logic [VOLT_W-1:0] join_axis(axis_t a);
        return (a.sg < 0) ? VOLT_W'(-a.mag) : VOLT_W'(a.mag);
    endfunction

    function automatic logic [63:0] root_floor(logic [127:0] n);
        logic [63:0] r;
        logic [63:0] t;
        r = 0;
        for (int b = 63; b >= 0; b--)
        begin
            t = r | (64'd1 << b);
            if (128'(t) * 128'(t) <= n)
                r = t;
        end
        return r;
    endfunction

    function automatic logic [63:0] q16_scale(logic [63:0] v, logic [63:0] k);
        return (v >> 16) * k + (((v & 64'hFFFF) * k) >> 16);
    endfunction

    function automatic logic cut_pair(input axis_t p, input axis_t o, input logic [63:0] lim,
                                      output axis_t po, output axis_t oo);
        logic [127:0] lsq;
        logic [127:0] psq;
        logic [63:0]  cap;
        logic [63:0]  pm;
        lsq = 128'(lim) * 128'(lim);
        po = p;
        oo = o;
        if (128'(p.mag) * 128'(p.mag) + 128'(o.mag) * 128'(o.mag) <= lsq)
            return 1'b0;
        cap = q16_scale(lim, 64'(CAP_Q16));
        pm = (p.mag > cap) ? cap : p.mag;
        psq = 128'(pm) * 128'(pm);
        po.mag = (p.sg != 0) ? pm : 0;
        oo.mag = (o.sg != 0) ? root_floor((lsq > psq) ? lsq - psq : 0) : 0;
        return 1'b1;
    endfunction

    function automatic limited_t limit_vector(logic [VOLT_W-1:0] d_in, logic [VOLT_W-1:0] q_in,
                                              logic [VOLT_W-1:0] x_in, logic [VOLT_W-1:0] y_in,
                                              logic [DC_W-1:0] dc, logic [VOLT_W-1:0] spd,
                                              logic [VOLT_W-1:0] iq, logic [MOD_W-1:0] idx);
        axis_t d, q, x, y, d_o, q_o, x_o, y_o;
        logic [63:0]  vmax;
        logic [63:0]  lxy;
        logic [63:0]  ldq;
        logic [127:0] vsq;
        logic [127:0] used;
        logic         cxy;
        logic         cdq;
        limited_t     r;
        d = split(d_in);
        q = split(q_in);
        x = split(x_in);
        y = split(y_in);
        vmax = q16_scale(64'(dc), 64'(idx));
        lxy = q16_scale(vmax, 64'(INV_SQRT2_Q16));
        cxy = cut_pair(y, x, lxy, y_o, x_o);
        vsq = 128'(vmax) * 128'(vmax);
        used = 128'(x_o.mag) * 128'(x_o.mag) + 128'(y_o.mag) * 128'(y_o.mag);
        ldq = root_floor((vsq > used) ? vsq - used : 0);
        if (split(spd).sg == split(iq).sg)
            cdq = cut_pair(d, q, ldq, d_o, q_o);
        else
            cdq = cut_pair(q, d, ldq, q_o, d_o);
        r.d = join_axis(d_o);
        r.q = join_axis(q_o);
        r.x = join_axis(x_o);
        r.y = join_axis(y_o);
        r.clamp = cxy | cdq;
        return r;
    endfunction

    task automatic report(string what, logic [VOLT_W-1:0] got, logic [VOLT_W-1:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t",
                 what, $signed(got), $signed(want), $realtime);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        limited_t e;
        if (!rst_n)
        begin
            fail_count = 0;
            accepted_in = 0;
            accepted_out = 0;
            clamp_count = 0;
            pending = 0;
            limited_q.delete();
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                limited_q.push_back(limit_vector(volt_d_in, volt_q_in, volt_x_in, volt_y_in,
                                                 dc_link_volt, elec_speed, current_ref_q,
                                                 mod_index));
                accepted_in++;
            end
            if (out_valid && !out_stall)
            begin
                accepted_out++;
                if (limited_q.size() == 0)
                    report("unexpected transaction", volt_d_out, 0);
                else
                begin
                    e = limited_q.pop_front();
                    if (volt_d_out !== e.d) report("volt_d_out", volt_d_out, e.d);
                    if (volt_q_out !== e.q) report("volt_q_out", volt_q_out, e.q);
                    if (volt_x_out !== e.x) report("volt_x_out", volt_x_out, e.x);
                    if (volt_y_out !== e.y) report("volt_y_out", volt_y_out, e.y);
                    if (clamped !== e.clamp) report("clamped", VOLT_W'(clamped), VOLT_W'(e.clamp));
                    if (e.clamp) clamp_count++;
                end
            end
            pending = limited_q.size();
        end
    end
endmodule

@@ verif/six_phase_voltage_vector_limiter_top_tb.sv @@
// testbench top of the six-phase voltage vector limiter: stimulus, configuration and verdict
module six_phase_voltage_vector_limiter_top_tb;
    import svvl_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 111;
    localparam int IDLE_LIMIT = 20000;
    localparam logic [2:0] MOD_ADDR = 3'd0;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic in_valid = 1'b0, in_stall;
    logic signed [VOLT_W-1:0] volt_d_in = '0, volt_q_in = '0, volt_x_in = '0, volt_y_in = '0;
    logic [DC_W-1:0] dc_link_volt = '0;
    logic signed [VOLT_W-1:0] elec_speed = '0, current_ref_q = '0;
    logic out_valid, out_stall = 1'b0;
    logic signed [VOLT_W-1:0] volt_d_out, volt_q_out, volt_x_out, volt_y_out;
    logic clamped;
    logic [MOD_W-1:0] mod_index = MOD_RESET;
    int fail_count, pending, accepted_in, accepted_out, clamp_count;
    int idle_cycles = 0;
    bit hold_off = 1'b0;
    bit stall_free = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    six_phase_voltage_vector_limiter_top dut (.*);

    svvl_checker chk (
        .clk, .rst_n, .in_valid, .in_stall, .volt_d_in, .volt_q_in, .volt_x_in, .volt_y_in,
        .dc_link_volt, .elec_speed, .current_ref_q, .out_valid, .out_stall, .volt_d_out,
        .volt_q_out, .volt_x_out, .volt_y_out, .clamped, .mod_index, .fail_count, .pending,
        .accepted_in, .accepted_out, .clamp_count
    );

    // receiver stall pattern, with a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_off || (!stall_free && $urandom_range(0, 3) == 0))
            out_stall <= 1'b1;
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("timeout: nothing accepted for %0d cycles", IDLE_LIMIT);
            $display("** six_phase_voltage_vector_limiter_top: FAILED **");
            $finish;
        end
    end

    task automatic write_mod(logic [MOD_W-1:0] v);
        @(posedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= MOD_ADDR; pwdata <= 32'(v);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        mod_index <= v;
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic drain();
        while (pending != 0) @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_volt();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'(0);
            3: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
            4: return 32'($signed($urandom_range(0, 60000000)) - 30000000);
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [DC_W-1:0] rand_dc();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return DC_W'($urandom_range(0, 50000000));
            default: return DC_W'($urandom());
        endcase
    endfunction

    task automatic send(logic [31:0] d, logic [31:0] q, logic [31:0] x, logic [31:0] y,
                        logic [DC_W-1:0] dc, logic [31:0] w, logic [31:0] iq);
        in_valid <= 1'b1;
        volt_d_in <= d; volt_q_in <= q; volt_x_in <= x; volt_y_in <= y;
        dc_link_volt <= dc; elec_speed <= w; current_ref_q <= iq;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic send_random(int count);
        int burst;
        int gap;
        while (count > 0)
        begin
            burst = $urandom_range(1, 30);
            while (burst > 0 && count > 0)
            begin
                send(rand_volt(), rand_volt(), rand_volt(), rand_volt(), rand_dc(),
                     rand_volt(), rand_volt());
                burst--;
                count--;
            end
            gap = $urandom_range(0, 6);
            if (count > 0 && gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_valid <= 1'b0;
    endtask

    initial
    begin
        logic [MOD_W-1:0] idx_set[5];
        idx_set = '{MOD_W'(1), MOD_W'(65536), MOD_W'(131071), MOD_W'(0), MOD_W'(52000)};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, both priorities, zero limits, three-phase case
        send(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, '1, 1, 1);
        send(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '1, 1, -1);
        send(32'h0100_0000, 32'h0100_0000, 0, 0, DC_W'(32'h0200_0000), 5, 7);
        send(32'h0100_0000, 32'h0100_0000, 0, 0, DC_W'(32'h0200_0000), -5, 7);
        send(32'h0100_0000, -32'h0100_0000, 0, 0, DC_W'(32'h0200_0000), 0, 0);
        send(32'h0100_0000, 32'h0100_0000, 32'h0050_0000, -32'h0090_0000,
             DC_W'(32'h0200_0000), 0, 3);
        send(1000, 2000, 3000, 4000, '0, 1, 1);
        send(0, 0, 0, 0, '0, 0, 0);
        send(0, 32'h0700_0000, 0, 32'h0700_0000, DC_W'(32'h0100_0000), 1, 1);
        send(32'h0700_0000, 0, 32'h0700_0000, 0, DC_W'(32'h0100_0000), -1, 1);
        send(10, -10, 20, -20, DC_W'(32'h1000_0000), 1, 1);
        in_valid <= 1'b0;
        drain();

        foreach (idx_set[i])
        begin
            write_mod(idx_set[i]);
            send_random(i == 3 ? 60 : 280);
            drain();
        end

        // long receiver hold-off so the pipeline fills and stalls its input
        write_mod(MOD_RESET);
        fork
            begin
                hold_off = 1'b1;
                repeat (400) @(posedge clk);
                hold_off = 1'b0;
            end
            send_random(200);
        join
        drain();
        stall_free = 1'b1;
        send_random(100);
        drain();

        $display("run covered %0d transactions in, %0d out, %0d clamped, %0d index settings",
                 accepted_in, accepted_out, clamp_count, 6);
        if (fail_count == 0)
            $display("** six_phase_voltage_vector_limiter_top: PASSED **");
        else
            $display("** six_phase_voltage_vector_limiter_top: FAILED **");
        $finish;
    end
endmodule
